@@ rtl/pirl_pkg.sv @@
// Shared types and constants for the positional insert/remove list.
package pirl_pkg;

	localparam int CMD_W    = 2;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 32;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;

	localparam int DUMP_LIMIT = 16;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	typedef logic [1:0] cell_op_t;

	localparam cell_op_t OP_HOLD = 2'd0;
	localparam cell_op_t OP_INS  = 2'd1;
	localparam cell_op_t OP_REM  = 2'd2;
	localparam cell_op_t OP_ROT  = 2'd3;

	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   pos;
	} cell_ctl_t;

endpackage

@@ rtl/positional_insert_remove_list.sv @@
// Positional insert/remove list: one slot per entry in a chain, each slot
// compares its own index with the command position, so insert, remove and
// clear complete in parallel across the slots and the next command can follow
// as soon as the result register has room. A dump rotates the occupied slots
// through the head once, one slot per cycle, waiting for room in the result
// register while it sends: it holds off new commands until the rotation is
// done and sends at most 16 entries, the final one marked last. A dump of an
// empty list, and every other command, gives exactly one result.
module positional_insert_remove_list import pirl_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [STAT_W-1:0]        status,
	output logic signed [DATA_W-1:0] entry_value,
	output logic [IDX_W-1:0]         entry_index,
	output logic [CNT_W-1:0]         count,
	output logic                     last
);

	localparam int LW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (LW > POS_W) ? LW : POS_W;
	localparam logic [CMPW-1:0] CAP_X  = CMPW'(CAPACITY);
	localparam logic [CMPW-1:0] LIM_X  = CMPW'(DUMP_LIMIT);
	localparam logic [CMPW-1:0] LIM1_X = CMPW'(DUMP_LIMIT - 1);

	logic [LW-1:0]            fill_q;
	logic [LW-1:0]            fill_d;
	logic                     dump_q;
	logic [LW-1:0]            step_q;
	logic                     res_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] entry_value_q;
	logic [IDX_W-1:0]         entry_index_q;
	logic [CNT_W-1:0]         count_q;
	logic                     last_q;

	logic                     space;
	logic                     accept;
	logic                     start_dump;
	logic                     silent;
	logic                     adv;
	logic                     emit;
	logic                     dump_last;
	logic [STAT_W-1:0]        res_st;
	logic [CMPW-1:0]          fill_x;
	logic [CMPW-1:0]          pos_x;
	logic [CMPW-1:0]          step_x;
	cell_ctl_t                ctl;

	logic signed [DATA_W-1:0] cell_val [CAPACITY];

	assign fill_x = CMPW'(fill_q);
	assign pos_x  = CMPW'(position);
	assign step_x = CMPW'(step_q);

	assign space     = !res_valid_q || !res_stall;
	assign cmd_stall = dump_q || !space;
	assign accept    = cmd_valid && !cmd_stall;

	assign silent    = step_x >= LIM_X;
	assign adv       = dump_q && (silent || space);
	assign emit      = adv && !silent;
	assign dump_last = (LW'(step_q + 1'b1) == fill_q) || (step_x == LIM1_X);

	always_comb begin
		res_st     = ST_OK;
		fill_d     = fill_q;
		start_dump = 1'b0;
		ctl.op     = OP_HOLD;
		ctl.pos    = position;
		if (accept) begin
			case (command)
				CMD_INSERT: begin
					if (pos_x > fill_x) begin
						res_st = ST_RANGE;
					end else if (fill_x == CAP_X) begin
						res_st = ST_FULL;
					end else begin
						ctl.op = OP_INS;
						fill_d = LW'(fill_q + 1'b1);
					end
				end
				CMD_REMOVE: begin
					if (pos_x >= fill_x) begin
						res_st = ST_RANGE;
					end else begin
						ctl.op = OP_REM;
						fill_d = LW'(fill_q - 1'b1);
					end
				end
				CMD_CLEAR: begin
					fill_d = '0;
				end
				CMD_DUMP: begin
					if (fill_q == '0) begin
						res_st = ST_EMPTY;
					end else begin
						start_dump = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (adv) begin
			ctl.op = OP_ROT;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [DATA_W-1:0] left_v;
		logic signed [DATA_W-1:0] right_v;

		if (g == 0) begin : g_first
			assign left_v = value;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end

		if (g == CAPACITY - 1) begin : g_end
			assign right_v = cell_val[g];
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end

		pirl_cell #(
			.IDX  (g),
			.LW   (LW),
			.CMPW (CMPW)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.fill    (fill_q),
			.left    (left_v),
			.right   (right_v),
			.head    (cell_val[0]),
			.ins_val (value),
			.data    (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			dump_q      <= 1'b0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (start_dump) begin
				dump_q <= 1'b1;
				step_q <= '0;
			end else if (adv) begin
				step_q <= LW'(step_q + 1'b1);
				if (step_q == LW'(fill_q - 1'b1)) begin
					dump_q <= 1'b0;
				end
			end
			if ((accept && !start_dump) || emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !start_dump) begin
			status_q      <= res_st;
			entry_value_q <= '0;
			entry_index_q <= '0;
			count_q       <= CNT_W'(fill_d);
			last_q        <= 1'b1;
		end else if (emit) begin
			status_q      <= ST_OK;
			entry_value_q <= cell_val[0];
			entry_index_q <= IDX_W'(step_q);
			count_q       <= CNT_W'(fill_q);
			last_q        <= dump_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign entry_value = entry_value_q;
	assign entry_index = entry_index_q;
	assign count       = count_q;
	assign last        = last_q;

endmodule

@@ rtl/pirl_cell.sv @@
// One list slot: holds an entry and takes its neighbor's on shift or rotate.
module pirl_cell import pirl_pkg::*; #(
	parameter int IDX  = 0,
	parameter int LW   = 5,
	parameter int CMPW = 5
) (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic [LW-1:0]            fill,
	input  logic signed [DATA_W-1:0] left,
	input  logic signed [DATA_W-1:0] right,
	input  logic signed [DATA_W-1:0] head,
	input  logic signed [DATA_W-1:0] ins_val,
	output logic signed [DATA_W-1:0] data
);

	localparam logic [CMPW-1:0] IDX_X  = CMPW'(IDX);
	localparam logic [CMPW-1:0] IDX1_X = CMPW'(IDX + 1);

	logic signed [DATA_W-1:0] data_q;
	logic [CMPW-1:0]          pos_x;
	logic [CMPW-1:0]          fill_x;

	assign pos_x  = CMPW'(ctl.pos);
	assign fill_x = CMPW'(fill);
	assign data   = data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (IDX_X > pos_x) begin
					data_q <= left;
				end else if (IDX_X == pos_x) begin
					data_q <= ins_val;
				end
			end
			OP_REM: begin
				if (IDX_X >= pos_x) begin
					data_q <= right;
				end
			end
			OP_ROT: begin
				data_q <= (IDX1_X == fill_x) ? head : right;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/pirl_chk.sv @@
// Port-level checks for the positional insert/remove list, bound to the top.
module pirl_chk import pirl_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cmd_valid,
	input logic                     cmd_stall,
	input logic [CMD_W-1:0]         command,
	input logic [POS_W-1:0]         position,
	input logic signed [DATA_W-1:0] value,
	input logic                     res_valid,
	input logic                     res_stall,
	input logic [STAT_W-1:0]        status,
	input logic signed [DATA_W-1:0] entry_value,
	input logic [IDX_W-1:0]         entry_index,
	input logic [CNT_W-1:0]         count,
	input logic                     last
);

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(command) && $stable(position)
			&& $stable(value))
		else $error("stalled command changed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(status) && $stable(entry_value)
			&& $stable(entry_index) && $stable(count) && $stable(last))
		else $error("stalled result changed");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> last)
		else $error("error result not marked last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> entry_value == '0 && entry_index == '0)
		else $error("error result carries entry data");

	a_dump_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |-> cmd_stall)
		else $error("command taken in the middle of a dump");

endmodule

bind positional_insert_remove_list pirl_chk u_pirl_chk (.*);
